// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property that must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ===== hw/rtl/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and constants of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned HeapBytes = 33554432;

  localparam logic       OpAlloc = 1'b0;
  localparam logic       OpFree  = 1'b1;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StHeapFull  = 2'd1;
  localparam logic [1:0] StTableFull = 2'd2;
  localparam logic [1:0] StBadFree   = 2'd3;

  localparam logic [1:0] SrcNew    = 2'd0;
  localparam logic [1:0] SrcRecent = 2'd1;
  localparam logic [1:0] SrcSearch = 2'd2;
  localparam logic [1:0] SrcNone   = 2'd3;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  localparam logic [1:0] CfgFitMode  = 2'd0;
  localparam logic [1:0] CfgMaxWaste = 2'd1;
  localparam logic [1:0] CfgHeader   = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StLaunch,
    StScan
  } state_e;

  typedef struct packed {
    logic        op;
    logic [25:0] request_bytes;
    logic [5:0]  free_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  source;
    logic [5:0]  block_handle;
    logic [24:0] payload_offset;
    logic [25:0] used_bytes;
    logic [31:0] waste_bytes;
  } res_t;

  // one table entry as held by a cell
  typedef struct packed {
    logic [25:0] size;
    logic [24:0] offset;
    logic        free;
    logic [5:0]  handle;
  } entry_t;

  // values seen by every cell during a scan
  typedef struct packed {
    logic [26:0] size;
    logic [5:0]  key;
    logic [1:0]  mode;
    logic [6:0]  count;
  } scan_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic        fhit;
    logic [5:0]  fidx;
    logic        ffree;
    logic [25:0] fsize;
    logic [24:0] foff;
    logic        shit;
    logic [5:0]  sidx;
    logic [25:0] ssize;
    logic [24:0] soff;
    logic [5:0]  shdl;
    logic [6:0]  ipos;
  } acc_t;

  // table update applied by all cells at once
  typedef struct packed {
    logic        clr_en;
    logic        set_en;
    logic [5:0]  idx;
    logic        ins_en;
    logic [6:0]  ins_pos;
    entry_t      ins;
  } cmd_t;

endpackage

// ===== hw/rtl/fpba_cell.sv =====
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry with its slice of the scan wave and insert shift.
// ----------------------------------------------------------------------------
module fpba_cell import fpba_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic [5:0] idx_i,
  input  scan_t  scan_i,
  input  cmd_t   cmd_i,
  input  entry_t prev_i,
  input  logic   tok_i,
  input  acc_t   acc_i,
  output entry_t entry_o,
  output logic   tok_o,
  output acc_t   acc_o
);

  entry_t ent_q, ent_d;
  acc_t   acc_q, acc_d;
  logic   tok_q;
  logic   valid, cand, take;

  // entry lies below the fill count
  assign valid = {1'b0, idx_i} < scan_i.count;
  assign cand  = valid && ent_q.free && ({1'b0, ent_q.size} >= scan_i.size);

  // fit policy choice against the best so far
  always_comb begin
    take = 1'b0;
    if (cand) begin
      if (!acc_i.shit) begin
        take = 1'b1;
      end else if (scan_i.mode == FitBest) begin
        take = ent_q.size <= acc_i.ssize;
      end else if (scan_i.mode == FitWorst) begin
        take = ent_q.size > acc_i.ssize;
      end
    end
  end

  // fold this entry into the scan result
  always_comb begin
    acc_d = acc_i;
    if (valid && !acc_i.fhit && ent_q.handle == scan_i.key) begin
      acc_d.fhit  = 1'b1;
      acc_d.fidx  = idx_i;
      acc_d.ffree = ent_q.free;
      acc_d.fsize = ent_q.size;
      acc_d.foff  = ent_q.offset;
    end
    if (take) begin
      acc_d.shit  = 1'b1;
      acc_d.sidx  = idx_i;
      acc_d.ssize = ent_q.size;
      acc_d.soff  = ent_q.offset;
      acc_d.shdl  = ent_q.handle;
    end
    if (valid && ({1'b0, ent_q.size} < scan_i.size)) begin
      acc_d.ipos = acc_i.ipos + 7'd1;
    end
  end

  // table update: shift, insert, free flag
  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins_en) begin
      if ({1'b0, idx_i} > cmd_i.ins_pos) begin
        ent_d = prev_i;
      end else if ({1'b0, idx_i} == cmd_i.ins_pos) begin
        ent_d = cmd_i.ins;
      end
    end
    if (cmd_i.clr_en && cmd_i.idx == idx_i) begin
      ent_d.free = 1'b0;
    end
    if (cmd_i.set_en && cmd_i.idx == idx_i) begin
      ent_d.free = 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (tok_i) begin
      acc_q <= acc_d;
    end
  end

  // wave token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign entry_o = ent_q;
  assign tok_o   = tok_q;
  assign acc_o   = acc_q;

endmodule

// ===== hw/rtl/fpba_row.sv =====
// ----------------------------------------------------------------------------
// fpba_row
// Row of table cells, sorted by block size.
// ----------------------------------------------------------------------------
module fpba_row import fpba_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  scan_t scan_i,
  input  cmd_t  cmd_i,
  input  logic  tok_i,
  output logic  tok_o,
  output acc_t  acc_o
);

  entry_t ent [MaxBlocks];
  entry_t prev [MaxBlocks];
  logic   tok [MaxBlocks+1];
  acc_t   acc [MaxBlocks+1];

  // empty scan result enters the first cell
  assign tok[0] = tok_i;
  assign acc[0] = '0;

  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev[g] = '0;
    end else begin : g_body
      assign prev[g] = ent[g-1];
    end
    fpba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (6'(g)),
      .scan_i  (scan_i),
      .cmd_i   (cmd_i),
      .prev_i  (prev[g]),
      .tok_i   (tok[g]),
      .acc_i   (acc[g]),
      .entry_o (ent[g]),
      .tok_o   (tok[g+1]),
      .acc_o   (acc[g+1])
    );
  end

  assign tok_o = tok[MaxBlocks];
  assign acc_o = acc[MaxBlocks];

endmodule

// ===== hw/rtl/fit_policy_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Heap block allocator: allocates by recent reuse, fit search or carve at the cursor, and frees blocks.
// ----------------------------------------------------------------------------
// sequence: an accepted request is captured and launched as a scan wave that passes
//   the 64-cell table row one cell per cycle; the request is decided as the wave
//   leaves the row, result and strobe registered; busy blocks a new request until then
// reset: counters, cursor, recent block, state and strobe cleared, settings set to
//   defaults; table contents are ignored until carved; results cannot be stalled
`include "assert_macros.svh"
module fit_policy_block_allocator_top import fpba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [1:0]  mode_q;
  logic [9:0]  max_waste_q;
  logic [7:0]  hdr_q;
  logic [6:0]  count_q, count_d;
  logic [25:0] cursor_q, cursor_d;
  logic        rv_q, rv_d;
  logic [5:0]  rh_q, rh_d;
  logic [25:0] used_q, used_d;
  logic [31:0] waste_q, waste_d;
  logic        op_q;
  logic [26:0] size_q;
  logic [5:0]  fh_q;
  logic        res_vld_q;
  res_t        res_q, res_d;
  logic [26:0] size_rnd;
  scan_t       scan;
  cmd_t        cmd;
  logic        tok_in, tok_out, finish;
  acc_t        acc;
  logic        rec_ok;
  logic [27:0] need;
  logic [25:0] spare;
  logic [32:0] wsum;
  logic [5:0]  ghdl;

  assign busy        = state_q != StIdle;
  // settings change only between requests
  assign cfg_ready_o = !busy;

  // round request up to a multiple of four bytes
  assign size_rnd = 27'(req_i.request_bytes) + 27'd3;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= FitFirst;
      max_waste_q <= 10'd10;
      hdr_q       <= 8'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgFitMode:  mode_q      <= cfg_data_i[1:0];
        CfgMaxWaste: max_waste_q <= cfg_data_i;
        CfgHeader:   hdr_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q   <= req_i.op;
      size_q <= {size_rnd[26:2], 2'b00};
      fh_q   <= req_i.free_handle;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (start) state_d = StLaunch;
      StLaunch: state_d = StScan;
      StScan:   if (tok_out) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    tok_in = state_q == StLaunch;
    finish = (state_q == StScan) && tok_out;
  end

  assign scan.size  = size_q;
  assign scan.key   = op_q ? fh_q : rh_q;
  assign scan.mode  = mode_q;
  assign scan.count = count_q;

  fpba_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan),
    .cmd_i  (cmd),
    .tok_i  (tok_in),
    .tok_o  (tok_out),
    .acc_o  (acc)
  );

  // decide the request once the wave leaves the row
  assign rec_ok = rv_q && acc.fhit && acc.ffree && ({1'b0, acc.fsize} >= size_q) &&
                  ((27'(acc.fsize) - size_q) <= 27'(max_waste_q));
  assign need   = 28'(cursor_q) + 28'(hdr_q) + 28'(size_q);
  assign spare  = rec_ok ? (acc.fsize - size_q[25:0]) : (acc.ssize - size_q[25:0]);
  assign wsum   = 33'(waste_q) + 33'(spare);
  assign ghdl   = rec_ok ? rh_q : acc.shdl;

  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    cursor_d = cursor_q;
    rv_d     = rv_q;
    rh_d     = rh_q;
    used_d   = used_q;
    waste_d  = waste_q;
    res_d    = '0;
    res_d.status = StOk;
    res_d.source = SrcNone;
    if (finish) begin
      if (op_q == OpFree) begin
        if (acc.fhit && !acc.ffree) begin
          cmd.set_en = 1'b1;
          cmd.idx    = acc.fidx;
          res_d.block_handle = fh_q;
          if (!rv_q) begin
            rv_d = 1'b1;
            rh_d = fh_q;
          end
        end else begin
          res_d.status = StBadFree;
        end
      end else if (rec_ok || acc.shit) begin
        cmd.clr_en = 1'b1;
        cmd.idx    = rec_ok ? acc.fidx : acc.sidx;
        waste_d    = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
        if (rv_q && rh_q == ghdl) begin
          rv_d = 1'b0;
        end
        res_d.source         = rec_ok ? SrcRecent : SrcSearch;
        res_d.block_handle   = ghdl;
        res_d.payload_offset = rec_ok ? acc.foff : acc.soff;
      end else if (need >= 28'(HeapBytes)) begin
        res_d.status = StHeapFull;
      end else if (count_q >= 7'(MaxBlocks)) begin
        res_d.status = StTableFull;
      end else begin
        cmd.ins_en        = 1'b1;
        cmd.ins_pos       = acc.ipos;
        cmd.ins.size      = size_q[25:0];
        cmd.ins.offset    = 25'(cursor_q + 26'(hdr_q));
        cmd.ins.free      = 1'b0;
        cmd.ins.handle    = count_q[5:0];
        count_d  = count_q + 7'd1;
        cursor_d = need[25:0];
        used_d   = used_q + 26'(hdr_q) + size_q[25:0];
        res_d.source         = SrcNew;
        res_d.block_handle   = count_q[5:0];
        res_d.payload_offset = cmd.ins.offset;
      end
      res_d.used_bytes  = used_d;
      res_d.waste_bytes = waste_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      cursor_q  <= '0;
      rv_q      <= 1'b0;
      rh_q      <= '0;
      used_q    <= '0;
      waste_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      rv_q      <= rv_d;
      rh_q      <= rh_d;
      used_q    <= used_d;
      waste_q   <= waste_d;
      res_vld_q <= finish;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  `ASSERT_CLK(a_res_after_scan, clk_i, rst_ni, res_valid_o |-> $past(state_q == StScan), "result without scan")
  `ASSERT_CLK(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "request not taken")
  `ASSERT_NEVER(a_count_cap, clk_i, rst_ni, count_q > 7'(MaxBlocks), "table overfilled")
  `ASSERT_NEVER(a_tok_idle, clk_i, rst_ni, tok_out && (state_q != StScan), "stray scan wave")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Block allocator testbench: allocate and free requests go in on the start /
// busy handshake while a behavioral model of the block table predicts each
// result, and a checker compares every strobed result field by field.
// ----------------------------------------------------------------------------
module tb;
  import fpba_pkg::*;

  localparam logic [1:0] FitAlias   = 2'd3;  // unused code, behaves as first fit
  localparam int unsigned CycleCap  = 2000000;
  localparam int unsigned DrainWait = 80;
  localparam int unsigned Rounds    = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [9:0]  cfg_data_i;

  fit_policy_block_allocator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // model of the block table and counters
  int unsigned blk_size [MaxBlocks];
  int unsigned blk_off  [MaxBlocks];
  bit          blk_free [MaxBlocks];
  int unsigned blk_hdl  [MaxBlocks];
  int unsigned blk_count;
  int unsigned cursor;
  bit          recent_ok;
  int unsigned recent_hdl;
  int unsigned used_total;
  int unsigned waste_total;
  logic [1:0]  fit_mode;
  int unsigned max_waste;
  int unsigned hdr_bytes;

  res_t        pending_res[$];
  int unsigned mismatches;
  int unsigned cycles;

  // clock and cycle limit
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int find_block(int unsigned h);
    for (int i = 0; i < blk_count; i++)
      if (blk_hdl[i] == h) return i;
    return -1;
  endfunction

  function automatic int fit_search(int unsigned size);
    int pick;
    pick = -1;
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_free[i] || blk_size[i] < size) continue;
      if (pick < 0) begin
        pick = i;
        if (fit_mode != FitBest && fit_mode != FitWorst) return pick;
      end else if (fit_mode == FitBest) begin
        if (blk_size[i] <= blk_size[pick]) pick = i;
      end else if (fit_mode == FitWorst) begin
        if (blk_size[i] > blk_size[pick]) pick = i;
      end
    end
    return pick;
  endfunction

  // hand a free block out again and account its spare bytes
  function automatic void reuse_block(int i, int unsigned spare);
    longint unsigned w;
    w = longint'(waste_total) + spare;
    blk_free[i]  = 1'b0;
    waste_total  = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    if (recent_ok && recent_hdl == blk_hdl[i]) recent_ok = 1'b0;
  endfunction

  // expected result of one request, updating the model
  function automatic res_t alloc_predict(req_t r);
    res_t            o;
    int              i;
    int              s;
    int unsigned     size;
    int unsigned     p;
    longint unsigned need;
    o = '0;
    o.status = StOk;
    o.source = SrcNone;
    if (r.op == OpFree) begin
      i = find_block(32'(r.free_handle));
      if (i < 0 || blk_free[i]) begin
        o.status = StBadFree;
      end else begin
        blk_free[i] = 1'b1;
        if (!recent_ok) begin
          recent_ok  = 1'b1;
          recent_hdl = 32'(r.free_handle);
        end
        o.block_handle = r.free_handle;
      end
    end else begin
      size = (int'(r.request_bytes) + 3) & ~32'd3;
      i = recent_ok ? find_block(recent_hdl) : -1;
      s = fit_search(size);
      if (i >= 0 && blk_free[i] && blk_size[i] >= size &&
          blk_size[i] - size <= max_waste) begin
        o.block_handle   = 6'(blk_hdl[i]);
        o.payload_offset = 25'(blk_off[i]);
        reuse_block(i, blk_size[i] - size);
        o.source = SrcRecent;
      end else if (s >= 0) begin
        o.block_handle   = 6'(blk_hdl[s]);
        o.payload_offset = 25'(blk_off[s]);
        reuse_block(s, blk_size[s] - size);
        o.source = SrcSearch;
      end else begin
        need = longint'(cursor) + hdr_bytes + size;
        if (need >= HeapBytes) begin
          o.status = StHeapFull;
        end else if (blk_count >= MaxBlocks) begin
          o.status = StTableFull;
        end else begin
          // insert in ascending size order
          p = 0;
          while (p < blk_count && blk_size[p] < size) p++;
          for (int k = blk_count; k > p; k--) begin
            blk_size[k] = blk_size[k-1];
            blk_off[k]  = blk_off[k-1];
            blk_free[k] = blk_free[k-1];
            blk_hdl[k]  = blk_hdl[k-1];
          end
          o.payload_offset = 25'(cursor + hdr_bytes);
          o.block_handle   = 6'(blk_count);
          blk_size[p] = size;
          blk_off[p]  = cursor + hdr_bytes;
          blk_free[p] = 1'b0;
          blk_hdl[p]  = blk_count;
          blk_count++;
          cursor     = need[31:0];
          used_total = (used_total + hdr_bytes + size) & 32'h3FF_FFFF;
          o.source   = SrcNew;
        end
      end
    end
    o.used_bytes  = 26'(used_total);
    o.waste_bytes = waste_total;
    return o;
  endfunction

  // result checker
  always @(negedge clk_i) begin
    res_t exp_res;
    if (rst_ni && res_valid_o) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected result %p", res_o);
      end else begin
        exp_res = pending_res.pop_front();
        if (res_o.status !== exp_res.status || res_o.source !== exp_res.source ||
            res_o.block_handle !== exp_res.block_handle ||
            res_o.payload_offset !== exp_res.payload_offset ||
            res_o.used_bytes !== exp_res.used_bytes ||
            res_o.waste_bytes !== exp_res.waste_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch expected %p actual %p", exp_res, res_o);
        end
      end
    end
  end

  // send one request after a gap; start stays high for a back-to-back request
  task automatic send_request(req_t r, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    pending_res.push_back(alloc_predict(r));
  endtask

  task automatic send_alloc(int unsigned nbytes);
    req_t r;
    r = '0;
    r.op = OpAlloc;
    r.request_bytes = 26'(nbytes);
    send_request(r, $urandom_range(0, 18));
  endtask

  task automatic send_free(int unsigned h);
    req_t r;
    r = '0;
    r.op = OpFree;
    r.free_handle = 6'(h);
    r.request_bytes = 26'($urandom);
    send_request(r, $urandom_range(0, 18));
  endtask

  // stop sending and wait for every expected result
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgFitMode:  fit_mode  = data[1:0];
      CfgMaxWaste: max_waste = 32'(data);
      CfgHeader:   hdr_bytes = 32'(data[7:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [1:0] mode, int unsigned waste, int unsigned hdr);
    write_reg(CfgFitMode, 10'(mode));
    write_reg(CfgMaxWaste, 10'(waste));
    write_reg(CfgHeader, 10'(hdr));
  endtask

  // zero size, rounding, recent reuse, bad frees and heap overflow at reset config
  task automatic test_basics;
    send_alloc(0);
    send_alloc(1);
    send_alloc(5);
    send_alloc(8);
    send_free(2);
    send_alloc(6);            // recent block reused
    send_free(2);
    send_free(2);             // already free
    send_free(63);            // never carved
    send_alloc(26'h3FF_FFFF); // heap exhausted
    send_alloc(HeapBytes);
    drain;
  endtask

  // same free set searched by every policy, ties included
  task automatic test_fit_modes;
    logic [1:0] modes [4];
    modes = '{FitFirst, FitBest, FitWorst, FitAlias};
    foreach (modes[m]) begin
      set_config(modes[m], 0, 255);
      send_alloc(40);
      send_alloc(40);
      send_alloc(100);
      send_free(blk_count - 1);
      send_free(blk_count - 2);
      send_free(blk_count - 3);
      send_alloc(20);
      send_alloc(20);
      drain;
    end
  endtask

  // mostly small allocations with frees of live handles, per config phase
  task automatic test_random;
    int unsigned sel;
    for (int ph = 0; ph < Rounds; ph++) begin
      case (ph)
        0: set_config(FitFirst, 1023, 0);
        1: set_config(FitBest, 0, 255);
        default: set_config(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                            $urandom_range(0, 255));
      endcase
      for (int n = 0; n < 160; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) send_free($urandom_range(0, (blk_count == 0) ? 0 : blk_count - 1));
        else if (sel < 45) send_free($urandom_range(0, 63));
        else if (sel < 80) send_alloc($urandom_range(0, 64));
        else if (sel < 97) send_alloc($urandom_range(0, 4096));
        else send_alloc($urandom_range(0, 26'h3FF_FFFF));
      end
      drain;
    end
  endtask

  // requests at the heap boundary
  task automatic test_heap_limit;
    int unsigned room;
    set_config(FitFirst, 10, 16);
    room = HeapBytes - cursor - hdr_bytes;
    send_alloc(room);
    send_alloc(room - 4);
    send_alloc(room);
    drain;
  endtask

  initial begin
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgFitMode;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    cycles      = 0;
    mismatches  = 0;
    blk_count   = 0;
    cursor      = 0;
    recent_ok   = 1'b0;
    recent_hdl  = 0;
    used_total  = 0;
    waste_total = 0;
    fit_mode    = FitFirst;
    max_waste   = 10;
    hdr_bytes   = 16;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basics;
    test_fit_modes;
    test_random;
    test_heap_limit;

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_cell.sv
hw/rtl/fpba_row.sv
hw/rtl/fit_policy_block_allocator_top.sv
tb/sv/tb.sv
